FILE: hdl/three_address_code_execute_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the three address code execute unit
// Same-cycle and next-cycle implication checks on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef THREE_ADDRESS_CODE_EXECUTE_UNIT_ASSERT_SVH
`define THREE_ADDRESS_CODE_EXECUTE_UNIT_ASSERT_SVH

// ante implies cons in the same cycle
`define TACEU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons in the next cycle
`define TACEU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/taceu_pkg.sv
// ----------------------------------------------------------------------------
// taceu_pkg
// Shared widths, command codes and control/status types of the execute unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package taceu_pkg;

    localparam int unsigned DATA_W        = 32;
    localparam int unsigned IDX_W         = 10;
    localparam int unsigned IDX_SPAN      = 1 << IDX_W;
    localparam int unsigned CMD_W         = 3;
    localparam int unsigned ALU_W         = 3;
    localparam int unsigned COND_W        = 2;
    localparam int unsigned ERR_W         = 2;
    localparam int unsigned VAR_COUNT_DEF = 1024;

    localparam logic [CMD_W-1:0] CMD_NOOP   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INPUT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_OUTPUT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ASSIGN = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CJUMP  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_JUMP   = 3'd5;

    localparam logic [ALU_W-1:0] ALU_PLUS  = 3'd0;
    localparam logic [ALU_W-1:0] ALU_MINUS = 3'd1;
    localparam logic [ALU_W-1:0] ALU_MUL   = 3'd2;
    localparam logic [ALU_W-1:0] ALU_DIV   = 3'd3;
    localparam logic [ALU_W-1:0] ALU_COPY  = 3'd4;

    localparam logic [COND_W-1:0] COND_GT = 2'd0;
    localparam logic [COND_W-1:0] COND_LT = 2'd1;
    localparam logic [COND_W-1:0] COND_NE = 2'd2;
    localparam logic [COND_W-1:0] COND_EQ = 2'd3;

    localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_DIV0    = 2'd1;
    localparam logic [ERR_W-1:0] ERR_INVALID = 2'd2;

    // index needs a true modulo (not a mask or a plain extension)
    function automatic logic needs_reduce(input int unsigned n);
        return (n < IDX_SPAN) && ((n & (n - 1)) != 0);
    endfunction

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic quo_load;
        logic mod_load;
        logic div_start;
        logic commit;
    } ctrl_t;

    typedef struct packed {
        logic clear_last;
        logic need_div;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

FILE: hdl/taceu_ram.sv
// ----------------------------------------------------------------------------
// taceu_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module taceu_ram #(
    parameter int unsigned WIDTH = taceu_pkg::DATA_W,
    parameter int unsigned DEPTH = taceu_pkg::VAR_COUNT_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire

FILE: hdl/taceu_div.sv
// ----------------------------------------------------------------------------
// taceu_div
// Signed truncating divider, restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module taceu_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [taceu_pkg::DATA_W-1:0] dividend,
    input  logic [taceu_pkg::DATA_W-1:0] divisor,
    output logic                        done,
    output logic [taceu_pkg::DATA_W-1:0] quotient
);

    import taceu_pkg::*;

    localparam int unsigned CNT_W = $clog2(DATA_W) + 1;

    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] dvs_reg;
    logic              neg_reg;

    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   trial;
    logic [DATA_W-1:0] rem_next;

    assign mag_a    = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
    assign mag_b    = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
    assign shifted  = {rem_reg, quo_reg[DATA_W-1]};
    assign trial    = shifted - {1'b0, dvs_reg};
    assign rem_next = trial[DATA_W] ? shifted[DATA_W-1:0] : trial[DATA_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(DATA_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= mag_a;
            dvs_reg <= mag_b;
            neg_reg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DATA_W-2:0], ~trial[DATA_W]};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;

endmodule

`default_nettype wire

FILE: hdl/taceu_datapath.sv
// ----------------------------------------------------------------------------
// taceu_datapath
// Instruction capture, index reduction, variable store, ALU and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module taceu_datapath #(
    parameter int unsigned VAR_COUNT = taceu_pkg::VAR_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  taceu_pkg::ctrl_t              ctrl,
    output taceu_pkg::stat_t              stat,
    input  logic [taceu_pkg::CMD_W-1:0]   cmd,
    input  logic [taceu_pkg::ALU_W-1:0]   alu_op,
    input  logic [taceu_pkg::COND_W-1:0]  cond_op,
    input  logic [taceu_pkg::IDX_W-1:0]   dest_index,
    input  logic [taceu_pkg::IDX_W-1:0]   src1_index,
    input  logic [taceu_pkg::IDX_W-1:0]   src2_index,
    input  logic signed [taceu_pkg::DATA_W-1:0] in_value,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          out_valid,
    output logic signed [taceu_pkg::DATA_W-1:0] out_value,
    output logic                          take_target,
    output logic [taceu_pkg::ERR_W-1:0]   error_code
);

    import taceu_pkg::*;

    localparam int unsigned AW    = $clog2(VAR_COUNT);
    localparam int unsigned RS    = 2 * IDX_W;
    localparam logic [RS-1:0] RECIP = RS'(((1 << RS) + VAR_COUNT - 1) / VAR_COUNT);

    // transaction capture
    logic [CMD_W-1:0]  cmd_reg;
    logic [ALU_W-1:0]  alu_reg;
    logic [COND_W-1:0] cond_reg;
    logic [IDX_W-1:0]  idx_reg [3];
    logic [DATA_W-1:0] value_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg    <= cmd;
            alu_reg    <= alu_op;
            cond_reg   <= cond_op;
            idx_reg[0] <= dest_index;
            idx_reg[1] <= src1_index;
            idx_reg[2] <= src2_index;
            value_reg  <= in_value;
        end
    end

    // index modulo VAR_COUNT: 0 dest, 1 src1, 2 src2
    logic [AW-1:0] addr [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_idx
        if (VAR_COUNT >= IDX_SPAN)
        begin : g_ext
            assign addr[i] = AW'(idx_reg[i]);
        end
        else if (!needs_reduce(VAR_COUNT))
        begin : g_mask
            assign addr[i] = idx_reg[i][AW-1:0];
        end
        else
        begin : g_mod
            logic [IDX_W+RS-1:0] prod;
            logic [IDX_W-1:0]    quo_reg;
            logic [IDX_W-1:0]    rem;
            logic [AW-1:0]       addr_reg;

            assign prod = (IDX_W + RS)'(idx_reg[i]) * (IDX_W + RS)'(RECIP);
            assign rem  = idx_reg[i] - quo_reg * IDX_W'(VAR_COUNT);

            always_ff @(posedge clk)
            begin
                if (ctrl.quo_load)
                begin
                    quo_reg <= prod[IDX_W+RS-1:RS];
                end
                if (ctrl.mod_load)
                begin
                    addr_reg <= rem[AW-1:0];
                end
            end

            assign addr[i] = addr_reg;
        end
    end

    // clearing pass counter
    logic [AW-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (ctrl.clear_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // variable store
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;

    taceu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (VAR_COUNT)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (addr[1]),
        .raddr_b (addr[2]),
        .rdata_a (a),
        .rdata_b (b)
    );

    // divider
    logic              div_done;
    logic [DATA_W-1:0] div_q;

    taceu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.div_start),
        .dividend (a),
        .divisor  (b),
        .done     (div_done),
        .quotient (div_q)
    );

    // execute
    logic              b_zero;
    logic              alu_ok;
    logic [DATA_W-1:0] mul_lo;
    logic [DATA_W-1:0] alu_res;
    logic              holds;
    logic              wr_var;
    logic              res_out_valid;
    logic [DATA_W-1:0] res_out_value;
    logic              res_take;
    logic [ERR_W-1:0]  res_err;

    assign b_zero = (b == '0);
    assign alu_ok = (alu_reg <= ALU_COPY);
    assign mul_lo = a * b;

    always_comb
    begin
        unique case (alu_reg)
            ALU_PLUS:  alu_res = a + b;
            ALU_MINUS: alu_res = a - b;
            ALU_MUL:   alu_res = mul_lo;
            ALU_DIV:   alu_res = div_q;
            ALU_COPY:  alu_res = a;
            default:   alu_res = '0;
        endcase
    end

    always_comb
    begin
        unique case (cond_reg)
            COND_GT: holds = $signed(a) > $signed(b);
            COND_LT: holds = $signed(a) < $signed(b);
            COND_NE: holds = (a != b);
            COND_EQ: holds = (a == b);
        endcase
    end

    always_comb
    begin
        wr_var        = 1'b0;
        res_out_valid = 1'b0;
        res_out_value = '0;
        res_take      = 1'b0;
        res_err       = ERR_OK;
        unique case (cmd_reg)
            CMD_NOOP:
            begin
            end
            CMD_INPUT:
            begin
                wr_var = 1'b1;
            end
            CMD_OUTPUT:
            begin
                res_out_valid = 1'b1;
                res_out_value = a;
            end
            CMD_ASSIGN:
            begin
                if (!alu_ok)
                begin
                    res_err = ERR_INVALID;
                end
                else if ((alu_reg == ALU_DIV) && b_zero)
                begin
                    res_err = ERR_DIV0;
                end
                else
                begin
                    wr_var = 1'b1;
                end
            end
            CMD_CJUMP:
            begin
                res_take = ~holds;
            end
            CMD_JUMP:
            begin
                res_take = 1'b1;
            end
            default:
            begin
                res_err = ERR_INVALID;
            end
        endcase
    end

    assign ram_we    = ctrl.clear_step | (ctrl.commit & wr_var);
    assign ram_waddr = ctrl.clear_step ? clr_cnt_reg : addr[0];
    assign ram_wdata = ctrl.clear_step ? '0 :
                       ((cmd_reg == CMD_INPUT) ? value_reg : alu_res);

    // result register
    logic              result_valid_reg;
    logic              result_valid_next;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic              take_reg;
    logic [ERR_W-1:0]  err_reg;

    assign result_valid_next = ctrl.commit | (result_valid_reg & result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            out_valid_reg <= res_out_valid;
            out_value_reg <= res_out_value;
            take_reg      <= res_take;
            err_reg       <= res_err;
        end
    end

    assign result_valid = result_valid_reg;
    assign out_valid    = out_valid_reg;
    assign out_value    = out_value_reg;
    assign take_target  = take_reg;
    assign error_code   = err_reg;

    assign stat.clear_last = (clr_cnt_reg == AW'(VAR_COUNT - 1));
    assign stat.need_div   = (cmd_reg == CMD_ASSIGN) && (alu_reg == ALU_DIV) && !b_zero;
    assign stat.div_done   = div_done;
    assign stat.out_free   = ~result_valid_reg | ~result_stall;

endmodule

`default_nettype wire

FILE: hdl/taceu_ctrl.sv
// ----------------------------------------------------------------------------
// taceu_ctrl
// Controller: clearing pass, capture, index reduction, read, execute, divide.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module taceu_ctrl #(
    parameter int unsigned VAR_COUNT = taceu_pkg::VAR_COUNT_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             instr_valid,
    output logic             instr_stall,
    input  taceu_pkg::stat_t stat,
    output taceu_pkg::ctrl_t ctrl
);

    import taceu_pkg::*;

    localparam logic REDUCE = needs_reduce(VAR_COUNT);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_QUO   = 3'd2;
    localparam logic [2:0] ST_MOD   = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;
    localparam logic [2:0] ST_OPER  = 3'd5;
    localparam logic [2:0] ST_DIV   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        ctrl        = '0;
        instr_stall = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ctrl.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                instr_stall = 1'b0;
                if (instr_valid)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = REDUCE ? ST_QUO : ST_READ;
                end
            end
            ST_QUO:
            begin
                ctrl.quo_load = 1'b1;
                state_next    = ST_MOD;
            end
            ST_MOD:
            begin
                ctrl.mod_load = 1'b1;
                state_next    = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_OPER;
            end
            ST_OPER:
            begin
                if (stat.need_div)
                begin
                    ctrl.div_start = 1'b1;
                    state_next     = ST_DIV;
                end
                else if (stat.out_free)
                begin
                    ctrl.commit = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (stat.div_done && stat.out_free)
                begin
                    ctrl.commit = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/three_address_code_execute_unit.sv
// ----------------------------------------------------------------------------
// three_address_code_execute_unit
// Executes one three address code instruction per transaction on a variable store.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------
//  instr    | instr_valid / instr_stall  | cmd alu_op cond_op dest_index
//           |                            | src1_index src2_index in_value
//  result   | result_valid / result_stall| out_valid out_value take_target error_code
//
//  Each transaction passes capture, store read and execute when VAR_COUNT is a
//  power of two or at least 1024; otherwise two index modulo stages follow capture.
//  A divide waits on the divider, which retires one quotient bit per cycle.
//  After reset a clearing pass writes zero to all VAR_COUNT words, one per cycle;
//  instr_stall stays high throughout the pass.
//  The result register holds a stalled transaction; the next one is accepted
//  meanwhile and waits at execute until the register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module three_address_code_execute_unit #(
    parameter int unsigned VAR_COUNT = taceu_pkg::VAR_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          instr_valid,
    output logic                          instr_stall,
    input  logic [taceu_pkg::CMD_W-1:0]   cmd,
    input  logic [taceu_pkg::ALU_W-1:0]   alu_op,
    input  logic [taceu_pkg::COND_W-1:0]  cond_op,
    input  logic [taceu_pkg::IDX_W-1:0]   dest_index,
    input  logic [taceu_pkg::IDX_W-1:0]   src1_index,
    input  logic [taceu_pkg::IDX_W-1:0]   src2_index,
    input  logic signed [taceu_pkg::DATA_W-1:0] in_value,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          out_valid,
    output logic signed [taceu_pkg::DATA_W-1:0] out_value,
    output logic                          take_target,
    output logic [taceu_pkg::ERR_W-1:0]   error_code
);

    import taceu_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    taceu_ctrl #(
        .VAR_COUNT (VAR_COUNT)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .instr_valid (instr_valid),
        .instr_stall (instr_stall),
        .stat        (stat),
        .ctrl        (ctrl)
    );

    taceu_datapath #(
        .VAR_COUNT (VAR_COUNT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .stat         (stat),
        .cmd          (cmd),
        .alu_op       (alu_op),
        .cond_op      (cond_op),
        .dest_index   (dest_index),
        .src1_index   (src1_index),
        .src2_index   (src2_index),
        .in_value     (in_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_valid    (out_valid),
        .out_value    (out_value),
        .take_target  (take_target),
        .error_code   (error_code)
    );

`include "three_address_code_execute_unit_assert.svh"

    `TACEU_ASSERT_NEXT(a_busy_after_accept, instr_valid && !instr_stall, instr_stall, "accepted while busy")
    `TACEU_ASSERT_SAME(a_commit_slot_free, ctrl.commit, stat.out_free, "commit into a full result register")
    `TACEU_ASSERT_SAME(a_clear_no_commit, ctrl.clear_step, !ctrl.commit && !ctrl.capture, "transaction during clearing pass")
    `TACEU_ASSERT_NEXT(a_div_restart, ctrl.div_start, !stat.div_done, "divider done not cleared by start")

endmodule

`default_nettype wire
